// File: design/assert_macros.svh
// Assertion macros used by the checker file of the tokenizer.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/fpet_pkg.sv
// Types and constants of the field path expression tokenizer.
// No dependencies; used by the front, back, top level and checker.
`timescale 1ns / 1ps

package fpet_pkg;

  typedef enum logic [2:0] {
    PH_START         = 3'd0,
    PH_SYM           = 3'd1,
    PH_SUB_FIRST     = 3'd2,
    PH_OCT           = 3'd3,
    PH_DEC           = 3'd4,
    PH_HEX           = 3'd5,
    PH_AFTER_BRACKET = 3'd6,
    PH_SKIP          = 3'd7
  } phase_e;

  typedef enum logic [2:0] {
    EV_NONE        = 3'd0,
    EV_SYMBOL      = 3'd1,
    EV_SUBSCRIPT   = 3'd2,
    EV_SYMBOL_DONE = 3'd3,
    EV_DONE        = 3'd4,
    EV_ERROR       = 3'd5
  } event_e;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  // Classified character as it travels from the front to the back.
  typedef struct packed {
    logic       is_nul;
    logic       is_dot;
    logic       is_lbr;
    logic       is_rbr;
    logic       is_x;
    logic       is_zero;
    logic       id_init;
    logic       oct_dig;
    logic       dec_dig;
    logic       hex_dig;
    logic [3:0] digit;
  } char_class_t;

endpackage

// File: design/fpet_front.sv
// Front of the tokenizer: accepts characters, classifies them and queues them.
// Depends on fpet_pkg.
`timescale 1ns / 1ps

module fpet_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           character_i,
  output logic                 q_valid_o,
  output fpet_pkg::char_class_t q_data_o,
  input  logic                 q_pop_i
);

  fpet_pkg::char_class_t cls;
  fpet_pkg::char_class_t fifo_q [fpet_pkg::QDEPTH];
  logic [fpet_pkg::QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [fpet_pkg::QCNT_W-1:0] count_q, count_d;
  logic push, pop;

  always_comb begin
    cls         = '0;
    cls.is_nul  = (character_i == 8'h00);
    cls.is_dot  = (character_i == 8'h2e);
    cls.is_lbr  = (character_i == 8'h5b);
    cls.is_rbr  = (character_i == 8'h5d);
    cls.is_x    = (character_i == 8'h78) || (character_i == 8'h58);
    cls.is_zero = (character_i == 8'h30);
    cls.id_init = character_i inside {[8'h61:8'h7a], [8'h41:8'h5a], 8'h5f, 8'h24};
    cls.oct_dig = character_i inside {[8'h30:8'h37]};
    cls.dec_dig = character_i inside {[8'h30:8'h39]};
    cls.hex_dig = character_i inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
    if (character_i inside {[8'h30:8'h39]}) begin
      cls.digit = 4'(character_i - 8'h30);
    end else if (character_i inside {[8'h41:8'h46]}) begin
      cls.digit = 4'(character_i - 8'h41 + 8'd10);
    end else begin
      cls.digit = 4'(character_i - 8'h61 + 8'd10);
    end
  end

  assign in_ready_o = (count_q != fpet_pkg::QCNT_W'(fpet_pkg::QDEPTH));
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (count_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_data_o   = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cls;
    end
  end

endmodule

// File: design/fpet_back.sv
// Back of the tokenizer: parse state machine and the output register.
// Depends on fpet_pkg; fed by fpet_front through its queue.
`timescale 1ns / 1ps

module fpet_back #(
  parameter int unsigned MAX_EXPR_LEN = 255
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  fpet_pkg::char_class_t q_data_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [2:0]            event_res_o,
  output logic [7:0]            segment_start_o,
  output logic [7:0]            segment_length_o,
  output logic [31:0]           subscript_value_o
);

  localparam int unsigned PosW = $clog2(MAX_EXPR_LEN + 1);
  localparam logic [PosW-1:0] MaxPos = PosW'(MAX_EXPR_LEN);

  fpet_pkg::phase_e phase_q, phase_d;
  logic [31:0]     acc_q, acc_d;
  logic [PosW-1:0] pos_q, pos_d, sym_q, sym_d;

  fpet_pkg::event_e ev;
  logic [7:0]  start, len;
  logic [31:0] val, scaled, sum;
  logic        err, add_ok, take;
  logic        out_valid_q;
  logic [2:0]  event_q;
  logic [7:0]  start_q, len_q;
  logic [31:0] val_q;

  fpet_pkg::char_class_t c;
  assign c = q_data_i;

  // One item per cycle as long as the output register is free or drains.
  assign q_pop_o = !out_valid_q || out_ready_i;
  assign take    = q_pop_o && q_valid_i;

  always_comb begin
    case (phase_q)
      fpet_pkg::PH_HEX: scaled = {acc_q[27:0], 4'b0};
      fpet_pkg::PH_DEC: scaled = {acc_q[28:0], 3'b0} + {acc_q[30:0], 1'b0};
      default:          scaled = {acc_q[28:0], 3'b0};
    endcase
    sum    = scaled + 32'(c.digit);
    add_ok = (sum != '1);
  end

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    pos_d   = pos_q;
    sym_d   = sym_q;
    ev      = fpet_pkg::EV_NONE;
    start   = '0;
    len     = '0;
    val     = '0;
    err     = 1'b0;
    if (phase_q == fpet_pkg::PH_SKIP) begin
      if (c.is_nul) begin
        phase_d = fpet_pkg::PH_START;
        acc_d   = '0;
        pos_d   = '0;
        sym_d   = '0;
      end
    end else begin
      if (!c.is_nul && pos_q >= MaxPos) begin
        err = 1'b1;
      end else begin
        case (phase_q)
          fpet_pkg::PH_START: begin
            if (c.id_init) begin
              sym_d   = pos_q;
              phase_d = fpet_pkg::PH_SYM;
            end else begin
              err = 1'b1;
            end
          end
          fpet_pkg::PH_SYM: begin
            if (c.is_dot || c.is_lbr || c.is_nul) begin
              start   = 8'(sym_q);
              len     = 8'(pos_q - sym_q);
              ev      = c.is_nul ? fpet_pkg::EV_SYMBOL_DONE : fpet_pkg::EV_SYMBOL;
              acc_d   = '0;
              phase_d = c.is_lbr ? fpet_pkg::PH_SUB_FIRST : fpet_pkg::PH_START;
            end
          end
          fpet_pkg::PH_SUB_FIRST: begin
            if (c.dec_dig) begin
              phase_d = c.is_zero ? fpet_pkg::PH_OCT : fpet_pkg::PH_DEC;
              acc_d   = 32'(c.digit);
            end else begin
              err = 1'b1;
            end
          end
          fpet_pkg::PH_OCT: begin
            if (acc_q == '0 && c.is_x) begin
              phase_d = fpet_pkg::PH_HEX;
            end else if (acc_q == '0 && c.is_zero) begin
              err = 1'b1;
            end else if (c.oct_dig) begin
              acc_d = sum;
              err   = !add_ok;
            end else if (c.is_rbr) begin
              ev      = fpet_pkg::EV_SUBSCRIPT;
              val     = acc_q;
              phase_d = fpet_pkg::PH_AFTER_BRACKET;
            end else begin
              err = 1'b1;
            end
          end
          fpet_pkg::PH_DEC: begin
            if (c.dec_dig) begin
              acc_d = sum;
              err   = !add_ok;
            end else if (c.is_rbr) begin
              ev      = fpet_pkg::EV_SUBSCRIPT;
              val     = acc_q;
              phase_d = fpet_pkg::PH_AFTER_BRACKET;
            end else begin
              err = 1'b1;
            end
          end
          fpet_pkg::PH_HEX: begin
            if (c.hex_dig) begin
              acc_d = sum;
              err   = !add_ok;
            end else if (c.is_rbr) begin
              ev      = fpet_pkg::EV_SUBSCRIPT;
              val     = acc_q;
              phase_d = fpet_pkg::PH_AFTER_BRACKET;
            end else begin
              err = 1'b1;
            end
          end
          fpet_pkg::PH_AFTER_BRACKET: begin
            // The character after a closing bracket is a separator; a bracket opens a subscript, a NUL ends.
            acc_d = '0;
            if (c.is_lbr) begin
              phase_d = fpet_pkg::PH_SUB_FIRST;
            end else if (c.is_nul) begin
              ev = fpet_pkg::EV_DONE;
            end else begin
              phase_d = fpet_pkg::PH_START;
            end
          end
          default: begin
            phase_d = fpet_pkg::PH_START;
          end
        endcase
      end

      if (err) begin
        ev    = fpet_pkg::EV_ERROR;
        start = '0;
        len   = '0;
        val   = '0;
      end
      if (c.is_nul) begin
        phase_d = fpet_pkg::PH_START;
        acc_d   = '0;
        pos_d   = '0;
        sym_d   = '0;
      end else if (err) begin
        phase_d = fpet_pkg::PH_SKIP;
      end else if (pos_q < MaxPos) begin
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= fpet_pkg::PH_START;
      acc_q       <= '0;
      pos_q       <= '0;
      sym_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        phase_q <= phase_d;
        acc_q   <= acc_d;
        pos_q   <= pos_d;
        sym_q   <= sym_d;
      end
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      event_q <= ev;
      start_q <= start;
      len_q   <= len;
      val_q   <= val;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign event_res_o       = event_q;
  assign segment_start_o   = start_q;
  assign segment_length_o  = len_q;
  assign subscript_value_o = val_q;

endmodule

// File: design/field_path_expression_tokenizer_unit.sv
// Channel  | Handshake                 | Payload
// ---------+---------------------------+------------------------------------------------
// in       | in_valid_i / in_ready_o   | character_i
// out      | out_valid_o / out_ready_i | event_res_o, segment_start_o, segment_length_o,
//          |                           | subscript_value_o
//
// One character per cycle sustained while the output drains; each transfer in yields
// one result (classification into a two-entry queue, then the parse state machine into
// the output register). The loop that sets the rate is the parse state update.
// Reset returns the parser to the start of an expression and empties the queue.
// A stalled output holds its register; the queue then fills and in_ready_o drops.
// Top level of the field path expression tokenizer; depends on fpet_pkg,
// fpet_front and fpet_back.
`timescale 1ns / 1ps

module field_path_expression_tokenizer_unit #(
  parameter int unsigned MAX_EXPR_LEN = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  character_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  event_res_o,
  output logic [7:0]  segment_start_o,
  output logic [7:0]  segment_length_o,
  output logic [31:0] subscript_value_o
);

  logic                  q_valid, q_pop;
  fpet_pkg::char_class_t q_data;

  fpet_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .character_i (character_i),
    .q_valid_o   (q_valid),
    .q_data_o    (q_data),
    .q_pop_i     (q_pop)
  );

  fpet_back #(
    .MAX_EXPR_LEN (MAX_EXPR_LEN)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_valid_i         (q_valid),
    .q_data_i          (q_data),
    .q_pop_o           (q_pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .event_res_o       (event_res_o),
    .segment_start_o   (segment_start_o),
    .segment_length_o  (segment_length_o),
    .subscript_value_o (subscript_value_o)
  );

endmodule

// File: design/fpet_checker.sv
// Port-level checks of the tokenizer, bound to the top level.
// Depends on fpet_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fpet_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  event_res_o,
  input logic [7:0]  segment_start_o,
  input logic [7:0]  segment_length_o,
  input logic [31:0] subscript_value_o
);

  logic is_sym;
  assign is_sym = (event_res_o == 3'(fpet_pkg::EV_SYMBOL)) ||
                  (event_res_o == 3'(fpet_pkg::EV_SYMBOL_DONE));

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(event_res_o) && $stable(subscript_value_o), "result changed while stalled")
  `ASSERT_SAME(a_event_code, clk_i, rst_ni, out_valid_o, event_res_o <= 3'(fpet_pkg::EV_ERROR), "event code out of range")
  `ASSERT_SAME(a_no_all_ones, clk_i, rst_ni, out_valid_o, subscript_value_o != 32'hFFFF_FFFF, "all-ones subscript reported")
  `ASSERT_SAME(a_sym_fields, clk_i, rst_ni, out_valid_o && !is_sym, segment_start_o == 8'd0 && segment_length_o == 8'd0, "symbol fields set without a symbol")
  `ASSERT_SAME(a_sub_field, clk_i, rst_ni, out_valid_o && event_res_o != 3'(fpet_pkg::EV_SUBSCRIPT), subscript_value_o == 32'd0, "subscript value set without a subscript")

endmodule

bind field_path_expression_tokenizer_unit fpet_checker u_fpet_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .event_res_o       (event_res_o),
  .segment_start_o   (segment_start_o),
  .segment_length_o  (segment_length_o),
  .subscript_value_o (subscript_value_o)
);
